// ===== sv/lbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared types and constants of the LED blink sequencer.
// ----------------------------------------------------------------------------
package lbs_pkg;

   // Width of the phase timers. The request fields stay 16 bits wide.
   localparam int TIME_WIDTH = 16;

   localparam int PRIO_WIDTH   = 8;
   localparam int FIELD_WIDTH  = 16;
   localparam int REQ_DATA_W   = 56;
   localparam int RSP_DATA_W   = 8;

   typedef enum logic [1:0] {
      ACT_TICK   = 2'd0,
      ACT_LAUNCH = 2'd1,
      ACT_STOP   = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_LIT  = 2'd1,
      PHASE_DARK = 2'd2
   } phase_type;

   typedef struct packed {
      logic      accepted;
      phase_type phase;
      logic      led_pin;
   } result_type;

endpackage

// ===== sv/lbs_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_core
// Sequencer state and the single-pass update for one transfer.
// ----------------------------------------------------------------------------
module lbs_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  lbs_pkg::action_type      action,
   input  logic [7:0]               request_priority,
   input  logic [15:0]              on_time,
   input  logic [15:0]              dark_time,
   input  logic [15:0]              repeat_count,
   input  logic                     idle_level,
   output lbs_pkg::result_type      result
);
   import lbs_pkg::*;

   phase_type               phase_ff,   phase_in;
   logic [TIME_WIDTH-1:0]   ticks_ff,   ticks_in;
   logic [FIELD_WIDTH-1:0]  repeats_ff, repeats_in;
   logic [PRIO_WIDTH-1:0]   owner_ff,   owner_in;
   logic [TIME_WIDTH-1:0]   lit_ff,     lit_in;
   logic [TIME_WIDTH-1:0]   dark_ff,    dark_in;
   logic                    allowed;
   logic                    accepted;

   always_comb begin
      phase_in   = phase_ff;
      ticks_in   = ticks_ff;
      repeats_in = repeats_ff;
      owner_in   = owner_ff;
      lit_in     = lit_ff;
      dark_in    = dark_ff;
      accepted   = 1'b0;
      allowed    = (phase_ff == PHASE_IDLE) || (request_priority >= owner_ff);
      unique case (action)
         ACT_TICK: begin
            if (phase_ff != PHASE_IDLE) begin
               if (ticks_ff > TIME_WIDTH'(1)) begin
                  ticks_in = ticks_ff - TIME_WIDTH'(1);
               end else if (phase_ff == PHASE_LIT) begin
                  if (repeats_ff != '0) begin
                     repeats_in = repeats_ff - FIELD_WIDTH'(1);
                     phase_in   = PHASE_DARK;
                     ticks_in   = dark_ff;
                  end else begin
                     phase_in = PHASE_IDLE;
                     ticks_in = '0;
                  end
               end else begin
                  phase_in = PHASE_LIT;
                  ticks_in = lit_ff;
               end
            end
         end
         ACT_LAUNCH: begin
            if (allowed) begin
               lit_in     = TIME_WIDTH'(on_time);
               dark_in    = TIME_WIDTH'(dark_time);
               repeats_in = repeat_count;
               owner_in   = request_priority;
               phase_in   = PHASE_LIT;
               ticks_in   = TIME_WIDTH'(on_time);
               accepted   = 1'b1;
            end
         end
         ACT_STOP: begin
            if (allowed) begin
               phase_in = PHASE_IDLE;
               ticks_in = '0;
               accepted = 1'b1;
            end
         end
         default: begin
            // The unused action code changes nothing.
         end
      endcase
   end

   always_comb begin
      result.accepted = accepted;
      result.phase    = phase_in;
      result.led_pin  = (phase_in == PHASE_LIT) ? ~idle_level : idle_level;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_IDLE;
         ticks_ff   <= '0;
         repeats_ff <= '0;
         owner_ff   <= '0;
         lit_ff     <= '0;
         dark_ff    <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         ticks_ff   <= ticks_in;
         repeats_ff <= repeats_in;
         owner_ff   <= owner_in;
         lit_ff     <= lit_in;
         dark_ff    <= dark_in;
      end
   end

endmodule

// ===== sv/lbs_rsp_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_rsp_reg
// Result register that holds one response until the sink takes it.
// ----------------------------------------------------------------------------
module lbs_rsp_reg (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  lbs_pkg::result_type                result,
   output logic                               can_load,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [lbs_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import lbs_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   // A new result may enter when the register is empty or being drained.
   assign can_load   = ~valid_ff | rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(data_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (can_load) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

endmodule

// ===== sv/led_blink_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_blink_sequencer
// Priority-preemptive LED flash sequencer paced by millisecond tick transfers.
// ----------------------------------------------------------------------------
// Response: registered; it appears in the cycle after its request's transfer.
// Throughput: one request per cycle; the state update and the response are
// computed in one pass and captured together by the sequencer and result
// registers, so only the result register's occupancy can hold off a request.
// Reset: synchronous, active high; the sequencer returns to idle with all
// timers, counts and the owner priority cleared, and idle_level goes to 0.
// ----------------------------------------------------------------------------
module led_blink_sequencer (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata, lowest bit up: request_priority[7:0], on_time[15:0],
   // dark_time[15:0], repeat_count[15:0].
   input  logic [lbs_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: action[1:0] (tick, launch or stop).
   input  logic [1:0]                       req_tuser,
   // Response channel.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata, lowest bit up: led_pin, phase[1:0], accepted, four zero bits.
   output logic [lbs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // Configuration write channel: idle_level.
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_wdata
);
   import lbs_pkg::*;

   logic       idle_level_ff;
   logic       can_load;
   logic       req_accept;
   result_type result;

   // The configuration register is always writable. The user must change it only
   // while the block is quiet, so the response of an in-flight request is unaffected; the block does not enforce this.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_level_ff <= 1'b0;
      end else if (csr_valid) begin
         idle_level_ff <= csr_wdata;
      end
   end

   // A request transfer happens whenever the result register can take the
   // response it produces; this lets requests stream at one per cycle.
   assign req_tready = can_load;
   assign req_accept = req_tvalid & req_tready;

   // The sequencer state advances only on an accepted request. Its response
   // carries the phase after the update and the pin level derived from it.
   lbs_core u_core (
      .clock            (clock),
      .reset            (reset),
      .accept           (req_accept),
      .action           (action_type'(req_tuser)),
      .request_priority (req_tdata[7:0]),
      .on_time          (req_tdata[23:8]),
      .dark_time        (req_tdata[39:24]),
      .repeat_count     (req_tdata[55:40]),
      .idle_level       (idle_level_ff),
      .result           (result)
   );

   // The result register decouples the two channels so a stalled sink costs
   // at most the one response it holds.
   lbs_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (req_accept),
      .result     (result),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Every accepted request leaves a response waiting in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_tvalid)
      else $error("request transfer produced no response");

   // A tick never reports an accepted command.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tuser == ACT_TICK) |=> !rsp_tdata[3])
      else $error("tick reported as accepted");

   // An accepted stop always leaves the sequencer idle.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tuser == ACT_STOP) |=>
         (!rsp_tdata[3] || rsp_tdata[2:1] == PHASE_IDLE))
      else $error("accepted stop did not go idle");

   // An accepted launch always starts a lit phase.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tuser == ACT_LAUNCH) |=>
         (!rsp_tdata[3] || rsp_tdata[2:1] == PHASE_LIT))
      else $error("accepted launch did not light");

endmodule
